@@ rtl/core/amt_pkg.sv @@
`timescale 1ns / 1ps

package amt_pkg;

    // table sizing
    localparam int DEPTH_DEFAULT = 64;
    localparam int DEPTH_MAX     = 1024;
    // wide enough for any cell index or entry count up to DEPTH_MAX
    localparam int POS_W         = $clog2(DEPTH_MAX + 1);

    // item kinds
    localparam logic [1:0] KIND_OBSERVE = 2'd0;
    localparam logic [1:0] KIND_PRUNE   = 2'd1;
    localparam logic [1:0] KIND_LOOKUP  = 2'd2;

    // register select, taken from paddr[2]
    localparam logic REG_CAPACITY  = 1'b0;
    localparam logic REG_AGE_LIMIT = 1'b1;

    // register reset values
    localparam logic [6:0]  CAPACITY_RESET  = 7'd64;
    localparam logic [31:0] AGE_LIMIT_RESET = 32'd60000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] mac_addr;
        logic [3:0]  channel;
        logic [31:0] now;
    } item_t;

    typedef struct packed {
        logic        hit;
        logic [5:0]  position;
        logic [3:0]  stored_channel;
        logic        evicted;
        logic [6:0]  removed_count;
        logic [6:0]  entry_count;
    } result_t;

    // one table entry as held by a cell
    typedef struct packed {
        logic [47:0] addr;
        logic [3:0]  chan;
        logic [31:0] seen;
    } entry_t;

    // broadcast control for the cell chain
    // cells with shift_lo <= index < shift_hi take their upper neighbor,
    // the cell at load_idx takes load data when load_en is set
    typedef struct packed {
        logic [POS_W-1:0] shift_lo;
        logic [POS_W-1:0] shift_hi;
        logic             load_en;
        logic [POS_W-1:0] load_idx;
    } cell_ctrl_t;

    typedef struct packed {
        logic [6:0]  capacity;
        logic [31:0] age_limit;
    } cfg_t;

endpackage

@@ rtl/core/amt_cell.sv @@
`timescale 1ns / 1ps

module amt_cell
    import amt_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     neighbor,
    input  entry_t     load_data,
    output entry_t     entry
);

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    entry_t entry_reg;
    entry_t entry_next;

    // load wins over shift, otherwise hold
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load_en && (ctrl.load_idx == MY_IDX))
        begin
            entry_next = load_data;
        end
        else if ((MY_IDX >= ctrl.shift_lo) && (MY_IDX < ctrl.shift_hi))
        begin
            entry_next = neighbor;
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ rtl/core/amt_seq.sv @@
`timescale 1ns / 1ps

module amt_seq
    import amt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       item_valid,
    output logic       item_stall,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result,
    input  entry_t     head,
    output cell_ctrl_t ctrl,
    output entry_t     load_data
);

    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int IW   = $clog2(TABLE_DEPTH);
    localparam int CMPW = ((CW > 7) ? CW : 7) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EDIT,
        S_FINISH
    } state_t;

    state_t          state_reg, state_next;
    item_t           item_reg, item_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [CW-1:0]   removed_reg, removed_next;
    logic            hit_reg, hit_next;
    logic [IW-1:0]   pos_reg, pos_next;
    logic [3:0]      chan_reg, chan_next;
    logic            evict_reg, evict_next;
    logic [IW-1:0]   best_idx_reg, best_idx_next;
    logic [31:0]     best_seen_reg, best_seen_next;
    logic            result_valid_reg, result_valid_next;
    result_t         result_reg, result_next;

    logic            match;
    logic            drop;
    logic [31:0]     age;
    logic            cap_reached;
    logic [CW-1:0]   n_less;
    logic [CW-1:0]   fill_less;
    entry_t          new_entry;

    // table full against the effective capacity (zero means one, saturates at depth)
    always_comb
    begin
        if (cfg.capacity == 7'd0)
        begin
            cap_reached = (fill_reg != '0);
        end
        else
        begin
            cap_reached = (CMPW'(fill_reg) >= CMPW'(cfg.capacity))
                       || (fill_reg == CW'(TABLE_DEPTH));
        end
    end

    // head entry checks
    assign n_less    = CW'(n_reg - CW'(1));
    assign fill_less = CW'(fill_reg - CW'(1));
    assign age       = item_reg.now - head.seen;
    assign match     = (head.addr == item_reg.mac_addr) && !hit_reg
                    && (item_reg.kind != KIND_PRUNE);
    assign drop      = (item_reg.kind == KIND_PRUNE) && (age >= cfg.age_limit);
    assign new_entry = '{addr: item_reg.mac_addr, chan: item_reg.channel, seen: item_reg.now};

    // sequencer next state
    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        fill_next         = fill_reg;
        n_next            = n_reg;
        k_next            = k_reg;
        removed_next      = removed_reg;
        hit_next          = hit_reg;
        pos_next          = pos_reg;
        chan_next         = chan_reg;
        evict_next        = evict_reg;
        best_idx_next     = best_idx_reg;
        best_seen_next    = best_seen_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        ctrl              = '0;
        load_data         = head;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next      = item;
                    n_next         = fill_reg;
                    k_next         = '0;
                    removed_next   = '0;
                    hit_next       = 1'b0;
                    pos_next       = '0;
                    chan_next      = 4'd0;
                    evict_next     = 1'b0;
                    best_idx_next  = '0;
                    best_seen_next = '0;
                    if ((item.kind == KIND_OBSERVE) || (item.kind == KIND_PRUNE)
                        || (item.kind == KIND_LOOKUP))
                    begin
                        if (fill_reg == '0)
                        begin
                            state_next = (item.kind == KIND_OBSERVE) ? S_EDIT : S_FINISH;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_SCAN:
            begin
                // rotate the window through the head, or close it up on a drop
                ctrl.shift_lo = '0;
                ctrl.shift_hi = POS_W'(n_less);
                ctrl.load_en  = !drop;
                ctrl.load_idx = POS_W'(n_less);
                if (match && (item_reg.kind == KIND_OBSERVE))
                begin
                    load_data = '{addr: head.addr, chan: item_reg.channel, seen: item_reg.now};
                end
                if (match)
                begin
                    hit_next  = 1'b1;
                    pos_next  = IW'(k_reg);
                    chan_next = head.chan;
                end
                // oldest so far, first one wins on ties
                if ((k_reg == '0) || (head.seen < best_seen_reg))
                begin
                    best_idx_next  = IW'(k_reg);
                    best_seen_next = head.seen;
                end
                if (drop)
                begin
                    n_next       = n_less;
                    removed_next = CW'(removed_reg + CW'(1));
                end
                k_next = CW'(k_reg + CW'(1));
                if (k_reg == fill_less)
                begin
                    fill_next  = drop ? n_less : n_reg;
                    state_next = (item_reg.kind == KIND_OBSERVE) ? S_EDIT : S_FINISH;
                end
            end

            S_EDIT:
            begin
                // miss: evict the oldest if full, then append
                if (!hit_reg)
                begin
                    ctrl.load_en = 1'b1;
                    load_data    = new_entry;
                    if (cap_reached)
                    begin
                        ctrl.shift_lo = POS_W'(best_idx_reg);
                        ctrl.shift_hi = POS_W'(fill_less);
                        ctrl.load_idx = POS_W'(fill_less);
                        evict_next    = 1'b1;
                    end
                    else
                    begin
                        ctrl.load_idx = POS_W'(fill_reg);
                        fill_next     = CW'(fill_reg + CW'(1));
                    end
                end
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next            = 1'b1;
                    result_next.hit              = hit_reg;
                    result_next.position         = 6'(pos_reg);
                    result_next.stored_channel   = chan_reg;
                    result_next.evicted          = evict_reg;
                    result_next.removed_count    = 7'(removed_reg);
                    result_next.entry_count      = 7'(fill_reg);
                    state_next                   = S_IDLE;
                end
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            fill_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            fill_reg         <= fill_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        n_reg         <= n_next;
        k_reg         <= k_next;
        removed_reg   <= removed_next;
        hit_reg       <= hit_next;
        pos_reg       <= pos_next;
        chan_reg      <= chan_next;
        evict_reg     <= evict_next;
        best_idx_reg  <= best_idx_next;
        best_seen_reg <= best_seen_next;
        result_reg    <= result_next;
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // window plus dropped entries always account for the table
    a_window_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ((n_reg + removed_reg) == fill_reg))
        else $error("scan window and removed count disagree with fill");

    // scan step never passes the last entry
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (k_reg < fill_reg))
        else $error("scan step beyond table fill");

    // an accepted transaction leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_IDLE) && item_valid) |=> (state_reg != S_IDLE))
        else $error("accepted transaction did not start");

    // eviction only on an observe that missed
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FINISH) && evict_reg)
            |-> (!hit_reg && (item_reg.kind == KIND_OBSERVE)))
        else $error("eviction without an observe miss");

endmodule

@@ rtl/core/aging_mac_table_oldest_evict.sv @@
`timescale 1ns / 1ps

// MAC learning table with aging, built as a chain of TABLE_DEPTH entry cells.
// One transaction is handled at a time. Each scan cycle moves the head cell's entry
// past one comparator and back into the chain. A lookup or prune scans every entry
// held on arrival and then finishes; an observe adds an edit step, and kind 3 goes
// straight to the finish. Eviction of the oldest entry and the append happen together
// in the edit step after the scan. A finished result waits in an output register
// while the next item is taken. The table is empty after reset and needs no clearing
// pass. Configuration registers: capacity at 0x0, age_limit at 0x4; write them only
// while idle.
module aging_mac_table_oldest_evict
    import amt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t       cfg_reg;
    cell_ctrl_t ctrl;
    entry_t     load_data;
    entry_t     cell_q [TABLE_DEPTH];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.capacity  <= CAPACITY_RESET;
            cfg_reg.age_limit <= AGE_LIMIT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_CAPACITY:  cfg_reg.capacity  <= pwdata[6:0];
                REG_AGE_LIMIT: cfg_reg.age_limit <= pwdata;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (paddr[2])
            REG_CAPACITY:  prdata = {25'd0, cfg_reg.capacity};
            REG_AGE_LIMIT: prdata = cfg_reg.age_limit;
        endcase
    end

    assign pready = 1'b1;

    // sequencer
    amt_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .head         (cell_q[0]),
        .ctrl         (ctrl),
        .load_data    (load_data)
    );

    // entry cell chain, each cell fed by its upper neighbor, the last one by itself
    for (genvar gi = 0; gi < TABLE_DEPTH; gi++)
    begin : g_cell
        if (gi == TABLE_DEPTH - 1)
        begin : g_last
            amt_cell #(
                .IDX (gi)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .neighbor  (cell_q[gi]),
                .load_data (load_data),
                .entry     (cell_q[gi])
            );
        end
        else
        begin : g_mid
            amt_cell #(
                .IDX (gi)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .neighbor  (cell_q[gi + 1]),
                .load_data (load_data),
                .entry     (cell_q[gi])
            );
        end
    end

endmodule
